### rtl/core/tstp_pkg.sv
`timescale 1ns / 1ps
package tstp_pkg;

	localparam logic [7:0] KIND_END  = 8'd0;
	localparam logic [7:0] KIND_NOP  = 8'd1;
	localparam logic [7:0] KIND_TSTP = 8'd8;

	localparam logic [5:0] POS_OFFSET   = 6'd12;
	localparam logic [5:0] POS_HDR_LAST = 6'd19;
	localparam logic [5:0] POS_MAX      = 6'd63;
	localparam logic [3:0] MIN_WORDS    = 4'd5;
	localparam logic [7:0] MIN_OPT_LEN  = 8'd2;
	localparam logic [7:0] TSTP_BYTES   = 8'd8;

	localparam logic [1:0] STAT_FOUND  = 2'd0;
	localparam logic [1:0] STAT_NO_OPT = 2'd1;
	localparam logic [1:0] STAT_ABSENT = 2'd2;
	localparam logic [1:0] STAT_BAD    = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_KIND    = 3'd1,
		PH_LEN     = 3'd2,
		PH_SKIP    = 3'd3,
		PH_CAPTURE = 3'd4,
		PH_FOUND   = 3'd5,
		PH_ABSENT  = 3'd6,
		PH_BAD     = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] seg_byte;
		logic       seg_last;
	} seg_item_t;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic [31:0] ts_value;
		logic [31:0] ts_echo;
	} res_item_t;

endpackage

### rtl/core/tcp_timestamp_option_parser_core.sv
`timescale 1ns / 1ps
// TCP timestamp option parser.
// Input channel seg: one segment byte per transaction, header first in wire
// order, seg_last set on the final byte of the segment.
// Output channel res: one transaction per segment, carrying the parse status
// and the two timestamp words (zero unless the timestamp was found).
// Both channels: a transaction completes on a rising edge with valid high
// and stall low.
// Throughput: one byte per cycle while seg_stall is low. A byte is taken
// into an input register, then the option walk updates its counters and
// phase, and the final byte of a segment loads the result register.
// When res stalls with a result pending, non-final bytes keep flowing; a
// final byte waits in the input register and seg_stall rises until the
// pending result is taken.
// Reset (arst_n low) empties both registers and returns the walk to the
// fixed header phase.
module tcp_timestamp_option_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  tstp_pkg::seg_item_t seg,
	output logic               res_valid,
	input  logic               res_stall,
	output tstp_pkg::res_item_t res
);
	import tstp_pkg::*;

	logic       valid_s1;
	seg_item_t  item_s1;
	logic       advance;
	logic       take_in;

	logic [5:0]  pos_q, pos_b, pos_n;
	logic [3:0]  words_q, words_b, words_n;
	phase_t      phase_q, phase_b, phase_n;
	logic [7:0]  skip_q, skip_b, skip_n;
	logic [63:0] stamp_q, stamp_b, stamp_n;
	logic        given_q;

	logic [5:0]  hdr_end;
	logic [8:0]  opt_reach;
	logic [1:0]  status_n;

	logic        res_valid_q;
	res_item_t   res_q;

	assign advance   = valid_s1 && (!item_s1.seg_last || !res_valid_q || !res_stall);
	assign seg_stall = valid_s1 && !advance;
	assign take_in   = seg_valid && !seg_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= seg;
		end
	end

	always_comb begin
		if (given_q) begin
			pos_b   = '0;
			words_b = '0;
			phase_b = PH_HEADER;
			skip_b  = '0;
			stamp_b = '0;
		end else begin
			pos_b   = pos_q;
			words_b = words_q;
			phase_b = phase_q;
			skip_b  = skip_q;
			stamp_b = stamp_q;
		end
	end

	assign hdr_end   = {words_b, 2'b00};
	assign opt_reach = {3'b000, pos_b} - 9'd1 + {1'b0, item_s1.seg_byte};

	always_comb begin
		words_n = words_b;
		phase_n = phase_b;
		skip_n  = skip_b;
		stamp_n = stamp_b;
		unique case (phase_b)
			PH_HEADER: begin
				if (pos_b == POS_OFFSET) begin
					words_n = item_s1.seg_byte[7:4];
				end
				if (pos_b == POS_HDR_LAST) begin
					phase_n = (words_n <= MIN_WORDS) ? PH_ABSENT : PH_KIND;
				end
			end
			PH_KIND: begin
				if (item_s1.seg_byte == KIND_END) begin
					phase_n = PH_ABSENT;
				end else if (item_s1.seg_byte == KIND_NOP) begin
					phase_n = ({1'b0, pos_b} + 7'd1 >= {1'b0, hdr_end}) ? PH_ABSENT : PH_KIND;
				end else if (item_s1.seg_byte == KIND_TSTP) begin
					if ({1'b0, pos_b} + 7'd10 > {1'b0, hdr_end}) begin
						phase_n = PH_BAD;
					end else begin
						skip_n  = 8'd1;
						phase_n = PH_LEN;
					end
				end else begin
					skip_n  = 8'd0;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				if (item_s1.seg_byte < MIN_OPT_LEN) begin
					phase_n = PH_BAD;
				end else if (skip_b == 8'd1) begin
					skip_n  = TSTP_BYTES;
					stamp_n = '0;
					phase_n = PH_CAPTURE;
				end else if (opt_reach >= {3'b000, hdr_end}) begin
					phase_n = PH_ABSENT;
				end else if (item_s1.seg_byte == MIN_OPT_LEN) begin
					phase_n = PH_KIND;
				end else begin
					skip_n  = item_s1.seg_byte - MIN_OPT_LEN;
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_n = skip_b - 8'd1;
				if (skip_n == 8'd0) begin
					phase_n = PH_KIND;
				end
			end
			PH_CAPTURE: begin
				stamp_n = {stamp_b[55:0], item_s1.seg_byte};
				skip_n  = skip_b - 8'd1;
				if (skip_n == 8'd0) begin
					phase_n = PH_FOUND;
				end
			end
			default: begin
			end
		endcase
		pos_n = (pos_b < POS_MAX) ? pos_b + 6'd1 : pos_b;
	end

	always_comb begin
		if (phase_n == PH_FOUND) begin
			status_n = STAT_FOUND;
		end else if (phase_n == PH_ABSENT) begin
			status_n = (words_n <= MIN_WORDS) ? STAT_NO_OPT : STAT_ABSENT;
		end else begin
			status_n = STAT_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			words_q <= '0;
			phase_q <= PH_HEADER;
			skip_q  <= '0;
			stamp_q <= '0;
			given_q <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			words_q <= words_n;
			phase_q <= phase_n;
			skip_q  <= skip_n;
			stamp_q <= stamp_n;
			given_q <= item_s1.seg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.seg_last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.seg_last) begin
			res_q.parse_status <= status_n;
			res_q.ts_value     <= (phase_n == PH_FOUND) ? stamp_n[63:32] : 32'd0;
			res_q.ts_echo      <= (phase_n == PH_FOUND) ? stamp_n[31:0] : 32'd0;
		end
	end

endmodule
